### src/ic3_pkg.sv
package ic3_pkg;

	// Default build parameters.
	localparam int MAX_WIDTH_DEF    = 2048;
	localparam int MAX_CHANNELS_DEF = 4;
	localparam int COEF_FRAC_DEF    = 8;

	// Fixed kernel geometry and queue size.
	localparam int KERNEL_SIZE = 3;
	localparam int TAP_COUNT   = KERNEL_SIZE * KERNEL_SIZE;
	localparam int OUT_DEPTH   = 8;

	// Configuration register indexes.
	localparam logic [2:0] REG_WIDTH    = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_CHANNELS = 3'd2;
	localparam logic [2:0] REG_KTOP     = 3'd3;
	localparam logic [2:0] REG_KMID     = 3'd4;
	localparam logic [2:0] REG_KBOT     = 3'd5;

	// Register reset values.
	localparam logic [11:0] WIDTH_RST    = 12'd640;
	localparam logic [15:0] HEIGHT_RST   = 16'd480;
	localparam logic [2:0]  CHANNELS_RST = 3'd3;
	localparam logic [47:0] KTOP_RST     = 48'd0;
	localparam logic [47:0] KMID_RST     = 48'd16777216;
	localparam logic [47:0] KBOT_RST     = 48'd0;

	// Input pixel.
	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic [7:0] chan_d;
	} pix_t;

	// Filtered result.
	typedef struct packed {
		logic [15:0] out_row;
		logic [10:0] out_col;
		logic [7:0]  res_a;
		logic [7:0]  res_b;
		logic [7:0]  res_c;
		logic [7:0]  res_d;
		logic        run_last;
	} res_t;

	// One convolution request from the window sequencer.
	typedef struct packed {
		logic        valid;
		logic        dv;
		logic        dh;
		logic [15:0] row;
		logic [10:0] col;
		logic        last;
	} iss_t;

endpackage

### src/image_convolution_3x3.sv
// 3x3 convolution over a raster pixel stream with zero padding at the edges.
// Input channel: in_valid, in_stall, in_data (one pixel, channel a in the low
// byte). A pixel is taken at an edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, out_data (row, column, four filtered
// channels, run_last on the final result caused by a pixel).
// Configuration: cfg_valid, cfg_ready, cfg_index, cfg_data; cfg_ready is
// always high and a write should only be made while the block is idle.
// Each pixel yields zero to four results: the pixel to its upper left, the
// row-end pixel above, and in the last row its left neighbor and row end.
// One pixel per cycle is taken while each pixel owes at most one result and
// the queue has room; the single convolution unit issues one result per cycle
// while the queue has room, so a pixel that owes several results holds the
// input until all are issued, and in the last row most pixels owe two results.
// An eight-entry output queue decouples the result stream; when the receiver
// stalls it fills and then stalls input.
// Reset clears counters, window and queue and loads the identity kernel,
// 640 by 480 pixels and three channels. The line stores need no clearing.
module image_convolution_3x3 import ic3_pkg::*; #(
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pix_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = 8 * MAX_CHANNELS;
	localparam int NW = $clog2(OUT_DEPTH + 1);

	logic [11:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  chans_q;
	logic [KERNEL_SIZE-1:0][47:0] kernel_q;

	logic [CW-1:0] col_last;
	logic [15:0]   row_last;
	logic [2:0]    nch;
	logic [31:0]   w_eff;
	logic          issue_ok;
	iss_t          iss;
	logic [TAP_COUNT-1:0][PW-1:0] window;
	logic          res_valid;
	res_t          res;
	logic [1:0]    busy;
	logic [NW-1:0] count;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			chans_q     <= CHANNELS_RST;
			kernel_q[0] <= KTOP_RST;
			kernel_q[1] <= KMID_RST;
			kernel_q[2] <= KBOT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:    width_q     <= cfg_data[11:0];
				REG_HEIGHT:   height_q    <= cfg_data[15:0];
				REG_CHANNELS: chans_q     <= cfg_data[2:0];
				REG_KTOP:     kernel_q[0] <= cfg_data;
				REG_KMID:     kernel_q[1] <= cfg_data;
				REG_KBOT:     kernel_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Clamped geometry and channel count.
	always_comb begin
		w_eff = (width_q == 12'd0) ? 32'd1 : 32'(width_q);
		if (w_eff > MAX_WIDTH) begin
			w_eff = MAX_WIDTH;
		end
		col_last = CW'(w_eff - 32'd1);
		row_last = (height_q == 16'd0) ? 16'd0 : height_q - 16'd1;
		if (chans_q == 3'd0) begin
			nch = 3'd1;
		end else if (32'(chans_q) > MAX_CHANNELS) begin
			nch = 3'(MAX_CHANNELS);
		end else begin
			nch = chans_q;
		end
	end

	// A result is issued only if the queue has room for it and all in flight.
	assign issue_ok = (32'(count) + 32'(busy)) < OUT_DEPTH;

	ic3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.col_last (col_last),
		.row_last (row_last),
		.issue_ok (issue_ok),
		.iss      (iss),
		.window   (window)
	);

	ic3_conv #(.MAX_CHANNELS(MAX_CHANNELS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss       (iss),
		.window    (window),
		.kernel    (kernel_q),
		.nch       (nch),
		.res_valid (res_valid),
		.res       (res),
		.busy      (busy)
	);

	ic3_fifo #(.DEPTH(OUT_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.pop    (out_valid && !out_stall),
		.dout   (out_data),
		.count  (count)
	);

	assign out_valid = (count != '0);

endmodule

### src/ic3_ram.sv
module ic3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ic3_front.sv
module ic3_front import ic3_pkg::*; #(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int PW = 8 * MAX_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  pix_t                     in_data,
	input  logic [CW-1:0]            col_last,
	input  logic [15:0]              row_last,
	input  logic                     issue_ok,
	output iss_t                     iss,
	output logic [TAP_COUNT-1:0][PW-1:0] window
);

	logic          accept;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic          last_col;
	logic          last_row;
	logic [31:0]   cur_full;

	logic          valid_s1;
	logic [PW-1:0] pix_s1;
	logic [15:0]   r_s1;
	logic [CW-1:0] c_s1;
	logic          last_col_s1;
	logic          last_row_s1;
	logic          fwd_s1;
	logic [PW-1:0] fwd_prev_s1;
	logic [PW-1:0] fwd_older_s1;
	logic [PW-1:0] prev_dout;
	logic [PW-1:0] older_dout;
	logic [PW-1:0] prev_eff;
	logic [PW-1:0] older_eff;

	logic [3:0]    mask_q;
	logic [3:0]    remain;
	logic [1:0]    sel;
	logic [15:0]   r_s2;
	logic [CW-1:0] c_s2;
	logic          fire;
	logic          s2_free;
	logic          move;
	logic [TAP_COUNT-1:0][PW-1:0] window_q;
	logic [TAP_COUNT-1:0][PW-1:0] win_nxt;

	// Input handshake: the input stage frees up when its pixel moves to the window.
	assign fire     = (mask_q != 4'd0) && issue_ok;
	assign s2_free  = (mask_q == 4'd0) || (fire && (remain == 4'd0));
	assign move     = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	assign last_col = col_q >= col_last;
	assign last_row = row_q >= row_last;
	assign cur_full = {in_data.chan_d, in_data.chan_c, in_data.chan_b, in_data.chan_a};

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Input stage register, with a bypass for a line store write to the address just read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= move && (c_s1 == col_q);
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= cur_full[PW-1:0];
			r_s1         <= row_q;
			c_s1         <= col_q;
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
			fwd_prev_s1  <= pix_s1;
			fwd_older_s1 <= prev_eff;
		end
	end

	assign prev_eff  = fwd_s1 ? fwd_prev_s1 : prev_dout;
	assign older_eff = fwd_s1 ? fwd_older_s1 : older_dout;

	// Line stores: the row above and the row two above.
	ic3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_prev (
		.clk   (clk),
		.we    (move),
		.waddr (c_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (prev_dout)
	);

	ic3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (move),
		.waddr (c_s1),
		.wdata (prev_eff),
		.re    (accept),
		.raddr (col_q),
		.rdata (older_dout)
	);

	// Next window: shift left by one column, cleared at the start of a row.
	always_comb begin
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
				win_nxt[i*KERNEL_SIZE+j] = (c_s1 == '0) ? '0 : window_q[i*KERNEL_SIZE+j+1];
			end
		end
		win_nxt[2] = (r_s1 >= 16'd2) ? older_eff : '0;
		win_nxt[5] = (r_s1 >= 16'd1) ? prev_eff : '0;
		win_nxt[8] = pix_s1;
	end

	// Pick the next pending result in emission order.
	always_comb begin
		priority if (mask_q[0]) begin
			sel = 2'd0;
		end else if (mask_q[1]) begin
			sel = 2'd1;
		end else if (mask_q[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
	end

	assign remain = mask_q & ~(4'd1 << sel);

	// Window register and the set of results still owed for its pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= 4'd0;
			window_q <= '0;
			r_s2     <= '0;
			c_s2     <= '0;
		end else if (move) begin
			mask_q[0] <= (r_s1 != 16'd0) && (c_s1 != '0);
			mask_q[1] <= (r_s1 != 16'd0) && last_col_s1;
			mask_q[2] <= last_row_s1 && (c_s1 != '0);
			mask_q[3] <= last_row_s1 && last_col_s1;
			window_q  <= win_nxt;
			r_s2      <= r_s1;
			c_s2      <= c_s1;
		end else if (fire) begin
			mask_q <= remain;
		end
	end

	// Request to the convolution pipeline.
	always_comb begin
		iss.valid = fire;
		iss.dv    = sel[1];
		iss.dh    = sel[0];
		iss.row   = sel[1] ? r_s2 : r_s2 - 16'd1;
		iss.col   = sel[0] ? 11'(c_s2) : 11'(c_s2 - 1'b1);
		iss.last  = (remain == 4'd0);
	end

	assign window = window_q;

endmodule

### src/ic3_conv.sv
module ic3_conv import ic3_pkg::*; #(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
	localparam int PW = 8 * MAX_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iss_t                          iss,
	input  logic [TAP_COUNT-1:0][PW-1:0]  window,
	input  logic [KERNEL_SIZE-1:0][47:0]  kernel,
	input  logic [2:0]                    nch,
	output logic                          res_valid,
	output res_t                          res,
	output logic [1:0]                    busy
);

	localparam logic [28:0] HALF = 29'd1 << (COEF_FRAC_BITS - 1);

	logic signed [24:0] prod_c  [MAX_CHANNELS][TAP_COUNT];
	logic signed [24:0] prod_s3 [MAX_CHANNELS][TAP_COUNT];
	logic [MAX_CHANNELS-1:0] en_s3;
	logic        v_s3;
	logic        v_s4;
	logic [15:0] row_s3;
	logic [15:0] row_s4;
	logic [10:0] col_s3;
	logic [10:0] col_s4;
	logic        last_s3;
	logic        last_s4;
	logic [28:0] rnd_c  [MAX_CHANNELS];
	logic [28:0] rnd_s4 [MAX_CHANNELS];
	logic [3:0][7:0] lane_res;

	// Products of every kernel coefficient with its shifted window tap.
	always_comb begin
		int ti;
		int tj;
		logic signed [15:0] k;
		logic signed [8:0]  p;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					ti = i + int'(iss.dv);
					tj = j + int'(iss.dh);
					k  = kernel[i][16*j +: 16];
					if (ti < KERNEL_SIZE && tj < KERNEL_SIZE) begin
						p = {1'b0, window[ti*KERNEL_SIZE+tj][8*ch +: 8]};
					end else begin
						p = '0;
					end
					prod_c[ch][i*KERNEL_SIZE+j] = k * p;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= iss.valid;
			v_s4 <= v_s3;
		end
	end

	// Product stage.
	always_ff @(posedge clk) begin
		prod_s3 <= prod_c;
		row_s3  <= iss.row;
		col_s3  <= iss.col;
		last_s3 <= iss.last;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			en_s3[ch] <= 32'(ch) < 32'(nch);
		end
	end

	// Sum, magnitude and rounding to whole units.
	always_comb begin
		logic signed [28:0] acc;
		logic [28:0] mag;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			acc = '0;
			for (int t = 0; t < TAP_COUNT; t++) begin
				acc = acc + 29'(prod_s3[ch][t]);
			end
			mag = acc[28] ? 29'(-acc) : 29'(acc);
			rnd_c[ch] = en_s3[ch] ? ((mag + HALF) >> COEF_FRAC_BITS) : 29'd0;
		end
	end

	always_ff @(posedge clk) begin
		rnd_s4  <= rnd_c;
		row_s4  <= row_s3;
		col_s4  <= col_s3;
		last_s4 <= last_s3;
	end

	// Modulo 255 by folding bytes, since 256 leaves 1.
	always_comb begin
		logic [31:0] x;
		logic [9:0]  s;
		logic [8:0]  f;
		lane_res = '0;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			x = 32'(rnd_s4[ch]);
			s = 10'(x[31:24]) + 10'(x[23:16]) + 10'(x[15:8]) + 10'(x[7:0]);
			f = 9'(s[9:8]) + 9'(s[7:0]);
			lane_res[ch] = (f >= 9'd255) ? 8'(f - 9'd255) : 8'(f);
		end
	end

	always_comb begin
		res.out_row  = row_s4;
		res.out_col  = col_s4;
		res.res_a    = lane_res[0];
		res.res_b    = lane_res[1];
		res.res_c    = lane_res[2];
		res.res_d    = lane_res[3];
		res.run_last = last_s4;
	end

	assign res_valid = v_s4;
	assign busy      = {1'b0, v_s3} + {1'b0, v_s4};

endmodule

### src/ic3_fifo.sv
module ic3_fifo import ic3_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH,
	localparam int AW = $clog2(DEPTH),
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  res_t          din,
	input  logic          pop,
	output res_t          dout,
	output logic [NW-1:0] count
);

	res_t          slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			count <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			count <= count + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	assign dout = slot_q[rd_q];

endmodule

### src/ic3_checker.sv
module ic3_checker import ic3_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input res_t out_data,
	input logic cfg_ready
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result request changed");

	// Filtered values are reduced modulo 255.
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.res_a != 8'hFF && out_data.res_b != 8'hFF &&
			out_data.res_c != 8'hFF && out_data.res_d != 8'hFF)
		else $error("filtered channel out of range");

	// The configuration port never back-pressures.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	// No result is offered right after reset.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result offered after reset");

endmodule

bind image_convolution_3x3 ic3_checker u_chk (.*);
